[rtl/npmr_pkg.sv]
// Package for the node pair mailbox rings: sizes, opcode and status codes,
// the decision struct and the ring-index and byte-mask helpers.
// No dependencies.
`timescale 1ns / 1ps

package npmr_pkg;

   localparam int MAX_NODES   = 8;
   localparam int RING_DEPTH  = 16;
   localparam int MSG_BYTES   = 8;

   localparam int NODE_W      = 3;
   localparam int LEN_W       = 4;
   localparam int DATA_W      = 64;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 3;
   localparam int COUNT_W     = 4;

   localparam int RING_COUNT  = MAX_NODES * (MAX_NODES - 1);
   localparam int RING_W      = $clog2(RING_COUNT);
   localparam int SLOT_W      = $clog2(RING_DEPTH);
   localparam int IDX_W       = 2 * SLOT_W;
   localparam int STORE_W     = DATA_W + LEN_W;
   localparam int STORE_DEPTH = RING_COUNT * RING_DEPTH;
   localparam int STORE_AW    = RING_W + SLOT_W;

   localparam logic [OP_W-1:0] OP_SEND     = 2'd0;
   localparam logic [OP_W-1:0] OP_RECV     = 2'd1;
   localparam logic [OP_W-1:0] OP_RECV_ANY = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LEN   = 3'd4;

   typedef struct packed {
      logic                push;
      logic                pop;
      logic [RING_W-1:0]   ring;
      logic [STATUS_W-1:0] status;
      logic [NODE_W-1:0]   source;
   } decision_type;

   // ring = to*(n-1) + from, one less when from > to
   function automatic logic [RING_W-1:0] ring_of(input logic [NODE_W-1:0]  from,
                                                  input logic [NODE_W-1:0]  to,
                                                  input logic [COUNT_W-1:0] n);
      logic [7:0] acc;
      acc = 8'(to) * 8'(n - 4'd1);
      acc = acc + 8'(from);
      if (from > to) begin
         acc = acc - 8'd1;
      end
      return acc[RING_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
      logic [DATA_W-1:0] m;
      m = '0;
      for (int i = 0; i < MSG_BYTES; i++) begin
         if (LEN_W'(i) < len) begin
            m[8*i +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

[rtl/node_pair_mailbox_rings.sv]
// Top level of the node pair mailbox rings: request decode, ring index and
// message stores, result register. Uses npmr_pkg, npmr_select, npmr_ram.
`timescale 1ns / 1ps

// One request is taken every cycle that start is high (busy stays low), and
// each request gives exactly one result beat on rsp_* with rsp_strobe high
// for a single cycle, after the request and result stage registers, in request order.
// The receiver cannot stall, so results must be taken as they appear. The rate
// of one request per cycle is set by the per-ring full/nonempty flags, which
// are decided at the request edge and updated in the index stage with a bypass
// from the index RAM stage. Reset takes effect at once: ring indices read as
// zero through per-ring valid bits, and the message store needs no clearing.
// The user must write node_count through csr_* only while no request is in
// flight; the block itself does not enforce this.
module node_pair_mailbox_rings (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [npmr_pkg::OP_W-1:0]        req_opcode,
   input  logic [npmr_pkg::NODE_W-1:0]      req_src_node,
   input  logic [npmr_pkg::NODE_W-1:0]      req_dst_node,
   input  logic [npmr_pkg::DATA_W-1:0]      req_payload,
   input  logic [npmr_pkg::LEN_W-1:0]       req_msg_length,
   output logic                             rsp_strobe,
   output logic [npmr_pkg::STATUS_W-1:0]    rsp_status,
   output logic [npmr_pkg::DATA_W-1:0]      rsp_read_payload,
   output logic [npmr_pkg::LEN_W-1:0]       rsp_read_length,
   output logic [npmr_pkg::NODE_W-1:0]      rsp_read_source,
   input  logic                             csr_write_en,
   input  logic [npmr_pkg::COUNT_W-1:0]     csr_write_data
);

   localparam int RC = npmr_pkg::RING_COUNT;
   localparam int SW = npmr_pkg::SLOT_W;

   // configuration
   logic [npmr_pkg::COUNT_W-1:0] node_count_ff, node_count_in;
   logic [npmr_pkg::COUNT_W-1:0] node_active;

   // per-ring flags
   logic [RC-1:0] nonempty_ff, nonempty_in;
   logic [RC-1:0] full_ff, full_in;
   logic [RC-1:0] idx_valid_ff, idx_valid_in;

   // request stage
   npmr_pkg::decision_type          dec;
   logic                            s1_valid_ff, s1_valid_in;
   logic                            s1_push_ff, s1_push_in;
   logic                            s1_pop_ff, s1_pop_in;
   logic [npmr_pkg::RING_W-1:0]     s1_ring_ff, s1_ring_in;
   logic [npmr_pkg::STATUS_W-1:0]   s1_status_ff, s1_status_in;
   logic [npmr_pkg::NODE_W-1:0]     s1_source_ff, s1_source_in;
   logic [npmr_pkg::LEN_W-1:0]      s1_len_ff, s1_len_in;
   logic [npmr_pkg::DATA_W-1:0]     s1_data_ff, s1_data_in;
   logic                            fwd_hit_ff, fwd_hit_in;
   logic [npmr_pkg::IDX_W-1:0]      fwd_idx_ff, fwd_idx_in;

   // index stage
   logic [npmr_pkg::IDX_W-1:0]      idx_q;
   logic [npmr_pkg::IDX_W-1:0]      idx_cur;
   logic [npmr_pkg::IDX_W-1:0]      idx_new;
   logic [SW-1:0]                   rd_cur, wr_cur, rd_next, wr_next;
   logic                            upd_b;
   logic                            ne_new, full_new;

   // result stage
   logic                            s2_valid_ff, s2_valid_in;
   logic                            s2_pop_ff, s2_pop_in;
   logic [npmr_pkg::STATUS_W-1:0]   s2_status_ff, s2_status_in;
   logic [npmr_pkg::NODE_W-1:0]     s2_source_ff, s2_source_in;
   logic [npmr_pkg::STORE_W-1:0]    store_q;

   assign busy = 1'b0;

   assign node_count_in = csr_write_en ? csr_write_data : node_count_ff;
   assign node_active   = (node_count_ff > npmr_pkg::COUNT_W'(npmr_pkg::MAX_NODES))
                        ? npmr_pkg::COUNT_W'(npmr_pkg::MAX_NODES) : node_count_ff;

   // ---------------- index stage ----------------
   assign idx_cur = fwd_hit_ff ? fwd_idx_ff
                  : (idx_valid_ff[s1_ring_ff] ? idx_q : '0);
   assign rd_cur  = idx_cur[npmr_pkg::IDX_W-1:SW];
   assign wr_cur  = idx_cur[SW-1:0];
   assign rd_next = SW'(rd_cur + 1'b1);
   assign wr_next = SW'(wr_cur + 1'b1);
   assign idx_new = s1_push_ff ? {rd_cur, wr_next} : {rd_next, wr_cur};
   assign upd_b   = s1_push_ff | s1_pop_ff;

   // full means one free slot left after this push
   assign ne_new   = s1_push_ff ? 1'b1 : (rd_next != wr_cur);
   assign full_new = s1_push_ff ? (SW'(wr_next + 1'b1) == rd_cur) : 1'b0;

   // flags as they stand after the beat in the index stage lands
   always_comb begin
      nonempty_in  = nonempty_ff;
      full_in      = full_ff;
      idx_valid_in = idx_valid_ff;
      if (upd_b) begin
         nonempty_in[s1_ring_ff]  = ne_new;
         full_in[s1_ring_ff]      = full_new;
         idx_valid_in[s1_ring_ff] = 1'b1;
      end
   end

   // ---------------- request stage ----------------
   npmr_select u_select (
      .opcode      (req_opcode),
      .src_node    (req_src_node),
      .dst_node    (req_dst_node),
      .msg_length  (req_msg_length),
      .node_active (node_active),
      .nonempty    (nonempty_in),
      .full        (full_in),
      .decision    (dec)
   );

   assign s1_valid_in  = start;
   assign s1_push_in   = start & dec.push;
   assign s1_pop_in    = start & dec.pop;
   assign s1_ring_in   = dec.ring;
   assign s1_status_in = dec.status;
   assign s1_source_in = dec.source;
   assign s1_len_in    = req_msg_length;
   assign s1_data_in   = req_payload & npmr_pkg::byte_mask(req_msg_length);

   // index RAM write and read of the same ring on one edge: take the new value
   assign fwd_hit_in = upd_b & (s1_push_in | s1_pop_in) & (s1_ring_ff == dec.ring);
   assign fwd_idx_in = idx_new;

   npmr_ram #(
      .WIDTH (npmr_pkg::IDX_W),
      .DEPTH (npmr_pkg::RING_COUNT)
   ) u_index_ram (
      .clock   (clock),
      .wr_en   (upd_b),
      .wr_addr (s1_ring_ff),
      .wr_data (idx_new),
      .rd_en   (s1_push_in | s1_pop_in),
      .rd_addr (dec.ring),
      .rd_data (idx_q)
   );

   npmr_ram #(
      .WIDTH (npmr_pkg::STORE_W),
      .DEPTH (npmr_pkg::STORE_DEPTH)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (s1_push_ff),
      .wr_addr ({s1_ring_ff, wr_cur}),
      .wr_data ({s1_len_ff, s1_data_ff}),
      .rd_en   (s1_pop_ff),
      .rd_addr ({s1_ring_ff, rd_cur}),
      .rd_data (store_q)
   );

   // ---------------- result stage ----------------
   assign s2_valid_in  = s1_valid_ff;
   assign s2_pop_in    = s1_pop_ff;
   assign s2_status_in = s1_status_ff;
   assign s2_source_in = s1_source_ff;

   assign rsp_strobe       = s2_valid_ff;
   assign rsp_status       = s2_status_ff;
   assign rsp_read_source  = s2_source_ff;
   assign rsp_read_payload = s2_pop_ff ? store_q[npmr_pkg::DATA_W-1:0] : '0;
   assign rsp_read_length  = s2_pop_ff ? store_q[npmr_pkg::STORE_W-1:npmr_pkg::DATA_W]
                                       : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= npmr_pkg::COUNT_W'(npmr_pkg::MAX_NODES);
         nonempty_ff   <= '0;
         full_ff       <= '0;
         idx_valid_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         s1_push_ff    <= 1'b0;
         s1_pop_ff     <= 1'b0;
         fwd_hit_ff    <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s2_pop_ff     <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         nonempty_ff   <= nonempty_in;
         full_ff       <= full_in;
         idx_valid_ff  <= idx_valid_in;
         s1_valid_ff   <= s1_valid_in;
         s1_push_ff    <= s1_push_in;
         s1_pop_ff     <= s1_pop_in;
         fwd_hit_ff    <= fwd_hit_in;
         s2_valid_ff   <= s2_valid_in;
         s2_pop_ff     <= s2_pop_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ring_ff   <= s1_ring_in;
      s1_status_ff <= s1_status_in;
      s1_source_ff <= s1_source_in;
      s1_len_ff    <= s1_len_in;
      s1_data_ff   <= s1_data_in;
      fwd_idx_ff   <= fwd_idx_in;
      s2_status_ff <= s2_status_in;
      s2_source_ff <= s2_source_in;
   end

endmodule

[rtl/npmr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module npmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/npmr_select.sv]
// Request decode: pair and length checks, ring lookup, full/empty decision
// and lowest-sender pick for receive-from-any. Uses npmr_pkg.
`timescale 1ns / 1ps

module npmr_select (
   input  logic [npmr_pkg::OP_W-1:0]       opcode,
   input  logic [npmr_pkg::NODE_W-1:0]     src_node,
   input  logic [npmr_pkg::NODE_W-1:0]     dst_node,
   input  logic [npmr_pkg::LEN_W-1:0]      msg_length,
   input  logic [npmr_pkg::COUNT_W-1:0]    node_active,
   input  logic [npmr_pkg::RING_COUNT-1:0] nonempty,
   input  logic [npmr_pkg::RING_COUNT-1:0] full,
   output npmr_pkg::decision_type          decision
);

   logic                          pair_ok;
   logic [npmr_pkg::RING_W-1:0]   ring_named;
   logic                          any_found;
   logic [npmr_pkg::NODE_W-1:0]   any_src;
   logic [npmr_pkg::RING_W-1:0]   any_ring;
   logic [npmr_pkg::RING_W-1:0]   cand_ring;

   assign pair_ok = (src_node != dst_node)
                 && (npmr_pkg::COUNT_W'(src_node) < node_active)
                 && (npmr_pkg::COUNT_W'(dst_node) < node_active);
   assign ring_named = npmr_pkg::ring_of(src_node, dst_node, node_active);

   // downward walk so the lowest sender wins
   always_comb begin
      any_found = 1'b0;
      any_src   = '0;
      any_ring  = '0;
      cand_ring = '0;
      for (int i = npmr_pkg::MAX_NODES - 1; i >= 0; i--) begin
         cand_ring = npmr_pkg::ring_of(npmr_pkg::NODE_W'(i), dst_node, node_active);
         if ((npmr_pkg::COUNT_W'(i) < node_active)
             && (npmr_pkg::NODE_W'(i) != dst_node)
             && nonempty[cand_ring]) begin
            any_found = 1'b1;
            any_src   = npmr_pkg::NODE_W'(i);
            any_ring  = cand_ring;
         end
      end
   end

   always_comb begin
      decision = '0;
      unique case (opcode)
         npmr_pkg::OP_SEND: begin
            priority if (!pair_ok) begin
               decision.status = npmr_pkg::ST_BAD;
            end else if (msg_length > npmr_pkg::LEN_W'(npmr_pkg::MSG_BYTES)) begin
               decision.status = npmr_pkg::ST_LEN;
            end else if (full[ring_named]) begin
               decision.status = npmr_pkg::ST_FULL;
            end else begin
               decision.push = 1'b1;
               decision.ring = ring_named;
            end
         end
         npmr_pkg::OP_RECV: begin
            priority if (!pair_ok) begin
               decision.status = npmr_pkg::ST_BAD;
            end else if (!nonempty[ring_named]) begin
               decision.status = npmr_pkg::ST_EMPTY;
            end else begin
               decision.pop    = 1'b1;
               decision.ring   = ring_named;
               decision.source = src_node;
            end
         end
         npmr_pkg::OP_RECV_ANY: begin
            priority if (npmr_pkg::COUNT_W'(dst_node) >= node_active) begin
               decision.status = npmr_pkg::ST_BAD;
            end else if (!any_found) begin
               decision.status = npmr_pkg::ST_EMPTY;
            end else begin
               decision.pop    = 1'b1;
               decision.ring   = any_ring;
               decision.source = any_src;
            end
         end
         default: begin
            decision = '0;
         end
      endcase
   end

endmodule

[verif/tb.sv]
// Self-checking testbench for node_pair_mailbox_rings: a queue-fed request driver,
// a response monitor and an in-bench mailbox predictor with its own ring state.
// Depends on npmr_pkg and the node_pair_mailbox_rings RTL.
`timescale 1ns / 1ps

module tb;
   import npmr_pkg::*;

   localparam logic [OP_W-1:0] OP_IDLE = 2'd3;

   typedef struct {
      bit [OP_W-1:0]   opcode;
      bit [NODE_W-1:0] src;
      bit [NODE_W-1:0] dst;
      bit [DATA_W-1:0] payload;
      bit [LEN_W-1:0]  len;
   } mbox_req_t;

   typedef struct {
      bit [STATUS_W-1:0] status;
      bit [DATA_W-1:0]   data;
      bit [LEN_W-1:0]    len;
      bit [NODE_W-1:0]   source;
      int                stamp;
   } mbox_rsp_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_opcode = '0;
   logic [NODE_W-1:0]   req_src_node = '0;
   logic [NODE_W-1:0]   req_dst_node = '0;
   logic [DATA_W-1:0]   req_payload = '0;
   logic [LEN_W-1:0]    req_msg_length = '0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [DATA_W-1:0]   rsp_read_payload;
   logic [LEN_W-1:0]    rsp_read_length;
   logic [NODE_W-1:0]   rsp_read_source;
   logic                csr_write_en = 1'b0;
   logic [COUNT_W-1:0]  csr_write_data = '0;

   // predictor state
   bit [COUNT_W-1:0] cfg_nodes = 4'd8;
   int               wr_ptr [RING_COUNT];
   int               rd_ptr [RING_COUNT];
   bit [DATA_W-1:0]  msg_mem [STORE_DEPTH];
   bit [LEN_W-1:0]   len_mem [STORE_DEPTH];

   mbox_req_t pend_q [$];
   mbox_rsp_t pending_rsp_q [$];
   int        cyc = 0;
   int        bad_beats = 0;

   node_pair_mailbox_rings u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_src_node     (req_src_node),
      .req_dst_node     (req_dst_node),
      .req_payload      (req_payload),
      .req_msg_length   (req_msg_length),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_read_payload (rsp_read_payload),
      .rsp_read_length  (rsp_read_length),
      .rsp_read_source  (rsp_read_source),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cyc <= cyc + 1;
   end

   function automatic bit pair_good(int from, int to, int n);
      return from != to && from < n && to < n;
   endfunction

   function automatic int ring_index(int from, int to, int n);
      return to * (n - 1) + from - ((from > to) ? 1 : 0);
   endfunction

   function automatic bit ring_take(int r, inout mbox_rsp_t rs);
      int h;
      int slot;
      h = rd_ptr[r];
      if (h == wr_ptr[r]) begin
         return 1'b0;
      end
      slot = r * RING_DEPTH + h;
      rs.data = msg_mem[slot];
      rs.len = len_mem[slot];
      rd_ptr[r] = (h + 1) % RING_DEPTH;
      return 1'b1;
   endfunction

   function automatic mbox_rsp_t mailbox_access(mbox_req_t rq);
      mbox_rsp_t       rs;
      int              n;
      int              r;
      int              t;
      int              slot;
      int              b;
      bit              found;
      bit [DATA_W-1:0] word;
      rs = '{default: '0};
      n = (cfg_nodes > MAX_NODES) ? MAX_NODES : int'(cfg_nodes);
      case (rq.opcode)
         OP_SEND: begin
            if (!pair_good(rq.src, rq.dst, n)) begin
               rs.status = ST_BAD;
            end else if (rq.len > MSG_BYTES) begin
               rs.status = ST_LEN;
            end else begin
               r = ring_index(rq.src, rq.dst, n);
               t = wr_ptr[r];
               if ((t + 1) % RING_DEPTH == rd_ptr[r]) begin
                  rs.status = ST_FULL;
               end else begin
                  // bytes past the length are dropped on the way in
                  word = rq.payload;
                  for (b = 0; b < MSG_BYTES; b++) begin
                     if (b >= rq.len) begin
                        word[8*b +: 8] = 8'h00;
                     end
                  end
                  slot = r * RING_DEPTH + t;
                  msg_mem[slot] = word;
                  len_mem[slot] = rq.len;
                  wr_ptr[r] = (t + 1) % RING_DEPTH;
               end
            end
         end
         OP_RECV: begin
            if (!pair_good(rq.src, rq.dst, n)) begin
               rs.status = ST_BAD;
            end else if (ring_take(ring_index(rq.src, rq.dst, n), rs)) begin
               rs.source = rq.src;
            end else begin
               rs.status = ST_EMPTY;
            end
         end
         OP_RECV_ANY: begin
            if (rq.dst >= n) begin
               rs.status = ST_BAD;
            end else begin
               found = 1'b0;
               for (b = 0; b < n; b++) begin
                  if (!found && b != rq.dst && ring_take(ring_index(b, rq.dst, n), rs)) begin
                     found = 1'b1;
                     rs.source = NODE_W'(b);
                  end
               end
               if (!found) begin
                  rs.status = ST_EMPTY;
               end
            end
         end
         default: begin
         end
      endcase
      return rs;
   endfunction

   // request driver
   always @(posedge clock) begin : drive_proc
      mbox_rsp_t pred_rsp;
      mbox_req_t cur;
      int        roll;
      static int gap_left = 0;
      static bit hold_drain = 1'b0;
      static bit no_idle = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            pred_rsp = mailbox_access('{req_opcode, req_src_node, req_dst_node,
                                        req_payload, req_msg_length});
            pred_rsp.stamp = cyc;
            pending_rsp_q.push_back(pred_rsp);
            if ($urandom_range(0, 39) == 0) begin
               no_idle = !no_idle;
            end
            roll = $urandom_range(0, 99);
            if (no_idle || roll < 60) begin
               gap_left = 0;
            end else if (roll < 90) begin
               gap_left = $urandom_range(1, 3);
            end else if (roll < 98) begin
               gap_left = $urandom_range(4, 10);
            end else begin
               gap_left = $urandom_range(20, 60);
            end
            if ($urandom_range(0, 99) == 0) begin
               hold_drain = 1'b1;
            end
         end
         if (hold_drain && pending_rsp_q.size() == 0) begin
            hold_drain = 1'b0;
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (!hold_drain && pend_q.size() > 0) begin
            cur = pend_q.pop_front();
            req_opcode     <= cur.opcode;
            req_src_node   <= cur.src;
            req_dst_node   <= cur.dst;
            req_payload    <= cur.payload;
            req_msg_length <= cur.len;
            start          <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // response monitor; an expectation stamped this edge is not yet due
   always @(posedge clock) begin : check_proc
      mbox_rsp_t want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp_q.size() == 0 || pending_rsp_q[0].stamp >= cyc) begin
            if (bad_beats < 10) begin
               $display("%0t: result beat with nothing pending: st=%0d data=%h len=%0d src=%0d",
                        $realtime, rsp_status, rsp_read_payload, rsp_read_length,
                        rsp_read_source);
            end
            bad_beats++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_status !== want.status || rsp_read_payload !== want.data ||
                rsp_read_length !== want.len || rsp_read_source !== want.source) begin
               if (bad_beats < 10) begin
                  $display("%0t: mismatch exp st=%0d data=%h len=%0d src=%0d", $realtime,
                           want.status, want.data, want.len, want.source);
                  $display("%0t:          got st=%0d data=%h len=%0d src=%0d", $realtime,
                           rsp_status, rsp_read_payload, rsp_read_length, rsp_read_source);
               end
               bad_beats++;
            end
         end
      end
   end

   function automatic mbox_req_t make_req(bit [OP_W-1:0] op, int from, int to,
                                          bit [DATA_W-1:0] data, int len);
      mbox_req_t rq;
      rq.opcode = op;
      rq.src = NODE_W'(from);
      rq.dst = NODE_W'(to);
      rq.payload = data;
      rq.len = LEN_W'(len);
      return rq;
   endfunction

   task automatic wait_idle();
      while (pend_q.size() != 0 || pending_rsp_q.size() != 0 || start) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   // one config setting followed by a burst of random requests
   task automatic run_phase(bit [COUNT_W-1:0] nodes, int count, int send_pct);
      mbox_req_t rq;
      int        nn;
      int        roll;
      int        hot_src;
      int        hot_dst;
      wait_idle();
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= nodes;
      cfg_nodes = nodes;
      @(posedge clock);
      csr_write_en <= 1'b0;
      nn = (nodes > MAX_NODES) ? MAX_NODES : int'(nodes);
      hot_dst = (nn >= 2) ? $urandom_range(0, nn - 1) : 0;
      hot_src = (nn >= 2) ? (hot_dst + $urandom_range(1, nn - 1)) % nn : 0;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         rq.payload = {$urandom, $urandom};
         case ($urandom_range(0, 9))
            0: rq.payload = '1;
            1: rq.payload = '0;
            default: begin
            end
         endcase
         rq.len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(9, 15))
                                              : LEN_W'($urandom_range(0, 8));
         if (roll < 8) begin
            // noise: any opcode, any node numbers
            rq.opcode = OP_W'($urandom_range(0, 3));
            rq.src = NODE_W'($urandom_range(0, 7));
            rq.dst = NODE_W'($urandom_range(0, 7));
         end else begin
            if (roll < 11) begin
               rq.opcode = OP_IDLE;
            end else if (roll < 11 + send_pct * 89 / 100) begin
               rq.opcode = OP_SEND;
            end else if ($urandom_range(0, 1) == 0) begin
               rq.opcode = OP_RECV;
            end else begin
               rq.opcode = OP_RECV_ANY;
            end
            if (nn < 2) begin
               rq.src = NODE_W'($urandom_range(0, 7));
               rq.dst = NODE_W'($urandom_range(0, 1));
            end else if ($urandom_range(0, 2) == 0) begin
               rq.src = NODE_W'(hot_src);
               rq.dst = NODE_W'(hot_dst);
            end else begin
               rq.dst = NODE_W'($urandom_range(0, nn - 1));
               rq.src = NODE_W'((rq.dst + $urandom_range(1, nn - 1)) % nn);
            end
         end
         pend_q.push_back(rq);
      end
   endtask

   initial begin
      foreach (wr_ptr[i]) begin
         wr_ptr[i] = 0;
         rd_ptr[i] = 0;
      end
      while (reset) begin
         @(posedge clock);
      end
      // directed requests on the reset node count of eight
      pend_q.push_back(make_req(OP_SEND, 0, 1, '1, 8));
      pend_q.push_back(make_req(OP_SEND, 0, 1, '1, 0));
      pend_q.push_back(make_req(OP_SEND, 0, 1, 64'h0123_4567_89AB_CDEF, 3));
      pend_q.push_back(make_req(OP_SEND, 7, 6, '1, 1));
      pend_q.push_back(make_req(OP_SEND, 6, 7, {$urandom, $urandom}, 8));
      pend_q.push_back(make_req(OP_SEND, 1, 1, '1, 4));
      pend_q.push_back(make_req(OP_SEND, 2, 3, '1, 9));
      pend_q.push_back(make_req(OP_SEND, 2, 3, '1, 15));
      pend_q.push_back(make_req(OP_SEND, 3, 3, '1, 15));
      pend_q.push_back(make_req(OP_RECV, 0, 1, '0, 0));
      pend_q.push_back(make_req(OP_RECV_ANY, 0, 1, '0, 0));
      pend_q.push_back(make_req(OP_RECV_ANY, 5, 1, '1, 15));
      pend_q.push_back(make_req(OP_RECV_ANY, 0, 1, '0, 0));
      pend_q.push_back(make_req(OP_RECV, 7, 6, '0, 0));
      pend_q.push_back(make_req(OP_RECV, 7, 6, '0, 0));
      pend_q.push_back(make_req(OP_RECV, 5, 5, '0, 0));
      pend_q.push_back(make_req(OP_RECV_ANY, 7, 7, '0, 0));
      pend_q.push_back(make_req(OP_IDLE, 7, 7, '1, 15));
      pend_q.push_back(make_req(OP_SEND, 5, 0, '0, 8));
      pend_q.push_back(make_req(OP_RECV_ANY, 3, 0, '0, 0));
      pend_q.push_back(make_req(OP_RECV_ANY, 7, 7, '0, 0));
      // ring contents carry over as the node count changes
      run_phase(4'd8, 250, 55);
      run_phase(4'd2, 200, 70);
      run_phase(4'd2, 100, 25);
      run_phase(4'd5, 200, 60);
      run_phase(4'd15, 200, 50);
      run_phase(4'd1, 60, 50);
      run_phase(4'd0, 40, 50);
      run_phase(4'd3, 150, 65);
      run_phase(4'd8, 150, 40);
      wait_idle();
      if (bad_beats == 0 && pending_rsp_q.size() == 0) begin
         $display("node_pair_mailbox_rings verification clean");
      end else begin
         $display("node_pair_mailbox_rings verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("node_pair_mailbox_rings verification failed");
      $finish;
   end

endmodule
